// File: design/cwmr_pkg.sv
// Shared constants, codes and types of the convolution window MAC block.
package cwmr_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_DEPTH  = 16;
	localparam int MAX_KERNEL = 5;

	localparam int PAD_LIMIT    = MAX_KERNEL / 2;
	localparam int STORE_W      = MAX_WIDTH + 2 * PAD_LIMIT;
	localparam int STORE_H      = MAX_HEIGHT + 2 * PAD_LIMIT;
	localparam int WEIGHT_COUNT = MAX_KERNEL * MAX_KERNEL * MAX_DEPTH;
	localparam int SAMPLE_COUNT = STORE_W * STORE_H * MAX_DEPTH;

	localparam int SA_W = $clog2(SAMPLE_COUNT);
	localparam int WA_W = $clog2(WEIGHT_COUNT);

	localparam int COORD_W  = 6;
	localparam int PY_W     = COORD_W + 1;
	localparam int DIM_W    = 7;
	localparam int KS_W     = 3;
	localparam int DEPTH_W  = 5;
	localparam int CH_W     = 4;
	localparam int PAD_W    = 2;
	localparam int REQ_W    = 2;
	localparam int VALUE_W  = 16;
	localparam int LEVEL_W  = 8;
	localparam int ACT_W    = 15;
	localparam int PROD_W   = 2 * VALUE_W;
	localparam int ACC_W    = 42;
	localparam int FRAC_SHIFT = 14;
	localparam int ACT_MAX  = (1 << ACT_W) - 1;

	localparam int REG_COUNT = 6;
	localparam int DATA_W    = 32;
	localparam int PADDR_W   = $clog2(REG_COUNT * 4);
	localparam int RIDX_W    = PADDR_W - 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_WEIGHT  = 2'd0,
		REQ_SAMPLE  = 2'd1,
		REQ_COMPUTE = 2'd2
	} req_t;

	typedef enum logic [RIDX_W-1:0] {
		REG_KERNEL = 3'd0,
		REG_DEPTH  = 3'd1,
		REG_WIDTH  = 3'd2,
		REG_HEIGHT = 3'd3,
		REG_BIAS   = 3'd4,
		REG_LEVEL  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [KS_W-1:0]           k;
		logic [PAD_W-1:0]          pad;
		logic [DIM_W-1:0]          w;
		logic [DIM_W-1:0]          h;
		logic [DEPTH_W-1:0]        d;
		logic signed [VALUE_W-1:0] bias;
		logic [LEVEL_W-1:0]        level;
	} cfg_t;

endpackage

// File: design/cwmr_regs.sv
// Configuration register file with APB-style access and clamped working values.
module cwmr_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cwmr_pkg::PADDR_W-1:0]  paddr,
	input  logic [cwmr_pkg::DATA_W-1:0]   pwdata,
	output logic [cwmr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output cwmr_pkg::cfg_t                cfg
);

	logic [cwmr_pkg::KS_W-1:0]           ks_q;
	logic [cwmr_pkg::DEPTH_W-1:0]        depth_q;
	logic [cwmr_pkg::DIM_W-1:0]          width_q;
	logic [cwmr_pkg::DIM_W-1:0]          height_q;
	logic signed [cwmr_pkg::VALUE_W-1:0] bias_q;
	logic [cwmr_pkg::LEVEL_W-1:0]        level_q;
	logic [cwmr_pkg::RIDX_W-1:0]         idx;
	logic                                wr;
	logic [cwmr_pkg::KS_W-1:0]           k_eff;

	assign pready = 1'b1;
	assign idx    = paddr[cwmr_pkg::PADDR_W-1:2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q     <= cwmr_pkg::KS_W'(3);
			depth_q  <= cwmr_pkg::DEPTH_W'(cwmr_pkg::MAX_DEPTH);
			width_q  <= cwmr_pkg::DIM_W'(cwmr_pkg::MAX_WIDTH);
			height_q <= cwmr_pkg::DIM_W'(cwmr_pkg::MAX_HEIGHT);
			bias_q   <= '0;
			level_q  <= '0;
		end else if (wr) begin
			case (idx)
				cwmr_pkg::REG_KERNEL: ks_q     <= pwdata[cwmr_pkg::KS_W-1:0];
				cwmr_pkg::REG_DEPTH:  depth_q  <= pwdata[cwmr_pkg::DEPTH_W-1:0];
				cwmr_pkg::REG_WIDTH:  width_q  <= pwdata[cwmr_pkg::DIM_W-1:0];
				cwmr_pkg::REG_HEIGHT: height_q <= pwdata[cwmr_pkg::DIM_W-1:0];
				cwmr_pkg::REG_BIAS:   bias_q   <= pwdata[cwmr_pkg::VALUE_W-1:0];
				cwmr_pkg::REG_LEVEL:  level_q  <= pwdata[cwmr_pkg::LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			cwmr_pkg::REG_KERNEL: prdata = cwmr_pkg::DATA_W'(ks_q);
			cwmr_pkg::REG_DEPTH:  prdata = cwmr_pkg::DATA_W'(depth_q);
			cwmr_pkg::REG_WIDTH:  prdata = cwmr_pkg::DATA_W'(width_q);
			cwmr_pkg::REG_HEIGHT: prdata = cwmr_pkg::DATA_W'(height_q);
			cwmr_pkg::REG_BIAS:   prdata = cwmr_pkg::DATA_W'(bias_q);
			cwmr_pkg::REG_LEVEL:  prdata = cwmr_pkg::DATA_W'(level_q);
			default:              prdata = '0;
		endcase
	end

	always_comb begin
		if (ks_q == '0) begin
			k_eff = cwmr_pkg::KS_W'(1);
		end else if (ks_q > cwmr_pkg::KS_W'(cwmr_pkg::MAX_KERNEL)) begin
			k_eff = cwmr_pkg::KS_W'(cwmr_pkg::MAX_KERNEL);
		end else begin
			k_eff = ks_q;
		end
	end

	assign cfg.k     = k_eff;
	assign cfg.pad   = cwmr_pkg::PAD_W'(k_eff >> 1);
	assign cfg.w     = (width_q > cwmr_pkg::DIM_W'(cwmr_pkg::MAX_WIDTH)) ?
		cwmr_pkg::DIM_W'(cwmr_pkg::MAX_WIDTH) : width_q;
	assign cfg.h     = (height_q > cwmr_pkg::DIM_W'(cwmr_pkg::MAX_HEIGHT)) ?
		cwmr_pkg::DIM_W'(cwmr_pkg::MAX_HEIGHT) : height_q;
	assign cfg.d     = (depth_q > cwmr_pkg::DEPTH_W'(cwmr_pkg::MAX_DEPTH)) ?
		cwmr_pkg::DEPTH_W'(cwmr_pkg::MAX_DEPTH) : depth_q;
	assign cfg.bias  = bias_q;
	assign cfg.level = level_q;

endmodule

// File: design/conv_window_mac_relu.sv
// Top level: sample and weight stores, tap sequencer, shared multiply-accumulate and ReLU.
// A load item does not raise busy. A compute item keeps busy high through the run, drain
// and finish states, one window tap per cycle through the shared multiplier, and its
// result beat appears on done in the cycle after the finish state; the next item may
// be accepted in that cycle. After reset a clearing pass zeroes the 73984-entry sample
// store, one entry a cycle, keeping busy high; configuration writes are taken meanwhile.
// The receiver cannot stall: each result beat lasts exactly one cycle on done.
module conv_window_mac_relu (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [cwmr_pkg::REQ_W-1:0]           req_type,
	input  logic [cwmr_pkg::COORD_W-1:0]         col,
	input  logic [cwmr_pkg::COORD_W-1:0]         row,
	input  logic [cwmr_pkg::CH_W-1:0]            channel,
	input  logic signed [cwmr_pkg::VALUE_W-1:0]  value,
	output logic                                 done,
	output logic [cwmr_pkg::COORD_W-1:0]         out_col,
	output logic [cwmr_pkg::COORD_W-1:0]         out_row,
	output logic [cwmr_pkg::LEVEL_W-1:0]         out_level,
	output logic [cwmr_pkg::ACT_W-1:0]           activation,
	output logic                                 saturated,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cwmr_pkg::PADDR_W-1:0]         paddr,
	input  logic [cwmr_pkg::DATA_W-1:0]          pwdata,
	output logic [cwmr_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	function automatic logic [cwmr_pkg::SA_W-1:0] sample_addr(
		input logic [cwmr_pkg::CH_W-1:0] ch,
		input logic [cwmr_pkg::PY_W-1:0] y,
		input logic [cwmr_pkg::PY_W-1:0] x
	);
		sample_addr = cwmr_pkg::SA_W'((cwmr_pkg::SA_W'(ch) * cwmr_pkg::SA_W'(cwmr_pkg::STORE_H)
			+ cwmr_pkg::SA_W'(y)) * cwmr_pkg::SA_W'(cwmr_pkg::STORE_W) + cwmr_pkg::SA_W'(x));
	endfunction

	function automatic logic [cwmr_pkg::WA_W-1:0] weight_addr(
		input logic [cwmr_pkg::CH_W-1:0] ch,
		input logic [cwmr_pkg::KS_W-1:0] ky,
		input logic [cwmr_pkg::KS_W-1:0] kx
	);
		weight_addr = cwmr_pkg::WA_W'((cwmr_pkg::WA_W'(ch) * cwmr_pkg::WA_W'(cwmr_pkg::MAX_KERNEL)
			+ cwmr_pkg::WA_W'(ky)) * cwmr_pkg::WA_W'(cwmr_pkg::MAX_KERNEL) + cwmr_pkg::WA_W'(kx));
	endfunction

	cwmr_pkg::cfg_t cfg;

	cwmr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic signed [cwmr_pkg::VALUE_W-1:0] sample_mem [cwmr_pkg::SAMPLE_COUNT];
	logic signed [cwmr_pkg::VALUE_W-1:0] weight_mem [cwmr_pkg::WEIGHT_COUNT];

	state_t                              state_q;
	logic [cwmr_pkg::SA_W-1:0]           clr_q;
	logic [cwmr_pkg::KS_W-1:0]           kx_q;
	logic [cwmr_pkg::KS_W-1:0]           ky_q;
	logic [cwmr_pkg::CH_W-1:0]           ch_q;
	logic [cwmr_pkg::COORD_W-1:0]        col_q;
	logic [cwmr_pkg::COORD_W-1:0]        row_q;
	logic                                drain_q;
	logic                                vld_s1;
	logic                                vld_s2;
	logic signed [cwmr_pkg::VALUE_W-1:0] samp_s1;
	logic signed [cwmr_pkg::VALUE_W-1:0] wt_s1;
	logic signed [cwmr_pkg::PROD_W-1:0]  prod_s2;
	logic signed [cwmr_pkg::ACC_W-1:0]   acc_q;

	logic                                accept;
	logic                                in_image;
	logic                                wt_in_range;
	logic                                s_we;
	logic [cwmr_pkg::SA_W-1:0]           s_waddr;
	logic signed [cwmr_pkg::VALUE_W-1:0] s_wdata;
	logic                                w_we;
	logic [cwmr_pkg::PY_W-1:0]           py;
	logic [cwmr_pkg::PY_W-1:0]           px;
	logic [cwmr_pkg::PY_W-1:0]           pad_ext;
	logic                                tap_ok;
	logic                                kx_last;
	logic                                ky_last;
	logic                                ch_last;
	logic [cwmr_pkg::ACC_W-1:0]          rounded;
	logic [cwmr_pkg::ACC_W-1:0]          scaled;
	logic                                acc_pos;
	logic                                clip;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_image = (cwmr_pkg::DIM_W'(col) < cfg.w) && (cwmr_pkg::DIM_W'(row) < cfg.h);
	assign wt_in_range = (col < cwmr_pkg::COORD_W'(cwmr_pkg::MAX_KERNEL))
		&& (row < cwmr_pkg::COORD_W'(cwmr_pkg::MAX_KERNEL));
	assign pad_ext  = cwmr_pkg::PY_W'(cfg.pad);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			s_we    = 1'b1;
			s_waddr = clr_q;
			s_wdata = '0;
		end else begin
			s_we    = accept && (req_type == cwmr_pkg::REQ_SAMPLE) && in_image;
			s_waddr = sample_addr(channel, cwmr_pkg::PY_W'(row) + pad_ext,
				cwmr_pkg::PY_W'(col) + pad_ext);
			s_wdata = value;
		end
	end

	assign w_we = accept && (req_type == cwmr_pkg::REQ_WEIGHT) && wt_in_range;

	assign py = cwmr_pkg::PY_W'(row_q) + cwmr_pkg::PY_W'(ky_q);
	assign px = cwmr_pkg::PY_W'(col_q) + cwmr_pkg::PY_W'(kx_q);
	assign tap_ok = (py >= pad_ext) && ((py - pad_ext) < cfg.h)
		&& (px >= pad_ext) && ((px - pad_ext) < cfg.w);

	assign kx_last = (kx_q == cfg.k - cwmr_pkg::KS_W'(1));
	assign ky_last = (ky_q == cfg.k - cwmr_pkg::KS_W'(1));
	assign ch_last = (cwmr_pkg::DEPTH_W'(ch_q) == cfg.d - cwmr_pkg::DEPTH_W'(1));

	always_ff @(posedge clk) begin
		if (s_we) begin
			sample_mem[s_waddr] <= s_wdata;
		end
		samp_s1 <= sample_mem[sample_addr(ch_q, py, px)];
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			weight_mem[weight_addr(channel, row[cwmr_pkg::KS_W-1:0], col[cwmr_pkg::KS_W-1:0])]
				<= value;
		end
		wt_s1 <= weight_mem[weight_addr(ch_q, ky_q, kx_q)];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= samp_s1 * wt_s1;
	end

	assign acc_pos = !acc_q[cwmr_pkg::ACC_W-1] && (acc_q != '0);
	assign rounded = cwmr_pkg::ACC_W'(acc_q)
		+ (cwmr_pkg::ACC_W'(1) << (cwmr_pkg::FRAC_SHIFT - 1));
	assign scaled  = rounded >> cwmr_pkg::FRAC_SHIFT;
	assign clip    = scaled > cwmr_pkg::ACC_W'(cwmr_pkg::ACT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			kx_q       <= '0;
			ky_q       <= '0;
			ch_q       <= '0;
			col_q      <= '0;
			row_q      <= '0;
			drain_q    <= 1'b0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			acc_q      <= '0;
			done       <= 1'b0;
			out_col    <= '0;
			out_row    <= '0;
			out_level  <= '0;
			activation <= '0;
			saturated  <= 1'b0;
		end else begin
			done   <= (state_q == ST_FINISH);
			vld_s1 <= (state_q == ST_RUN) && tap_ok;
			vld_s2 <= vld_s1;
			if (vld_s2) begin
				acc_q <= acc_q + cwmr_pkg::ACC_W'(prod_s2);
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + cwmr_pkg::SA_W'(1);
					if (clr_q == cwmr_pkg::SA_W'(cwmr_pkg::SAMPLE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (req_type == cwmr_pkg::REQ_COMPUTE) && in_image) begin
						col_q   <= col;
						row_q   <= row;
						kx_q    <= '0;
						ky_q    <= '0;
						ch_q    <= '0;
						drain_q <= 1'b0;
						acc_q   <= cwmr_pkg::ACC_W'(cfg.bias) <<< cwmr_pkg::FRAC_SHIFT;
						state_q <= (cfg.d == '0) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					if (!kx_last) begin
						kx_q <= kx_q + cwmr_pkg::KS_W'(1);
					end else begin
						kx_q <= '0;
						if (!ky_last) begin
							ky_q <= ky_q + cwmr_pkg::KS_W'(1);
						end else begin
							ky_q <= '0;
							if (ch_last) begin
								state_q <= ST_DRAIN;
							end else begin
								ch_q <= ch_q + cwmr_pkg::CH_W'(1);
							end
						end
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					out_col   <= col_q;
					out_row   <= row_q;
					out_level <= cfg.level;
					if (!acc_pos) begin
						activation <= '0;
						saturated  <= 1'b0;
					end else if (clip) begin
						activation <= cwmr_pkg::ACT_W'(cwmr_pkg::ACT_MAX);
						saturated  <= 1'b1;
					end else begin
						activation <= scaled[cwmr_pkg::ACT_W-1:0];
						saturated  <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
